// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/camray_pkg.sv
// ----------------------------------------------------------------------------
// Camera ray direction package
// Item types, register indexes and datapath widths of the ray direction unit.
// ----------------------------------------------------------------------------
package camray_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_COS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COS_Z = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM  = 3'd6;

  localparam int SQ_STEPS  = 27;
  localparam int DIV_STEPS = 16;

  typedef struct packed {
    logic signed [11:0] pixel_x;
    logic signed [11:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               zero_length;
  } out_item_t;

endpackage

// File: rtl/core/camera_ray_direction_unit.sv
// ----------------------------------------------------------------------------
// Camera ray direction unit
// Rotates a per-pixel camera vector by three angles and normalizes it.
// ----------------------------------------------------------------------------
// An item (pixel_x, pixel_y) is taken at each rising edge with start high and
// busy low; busy is always low, so one item may enter in every cycle.
// Each result appears on out_data for one cycle with out_valid high, in the
// order items entered. The pipeline holds the scaling, rotation, squaring and
// summing stages, 27 square root steps, 16 division steps and the output
// register. Throughput is one item per cycle.
// The receiver cannot stall the output, so no result is ever held back.
// Registers must be written through cfg_valid/cfg_ready/cfg_index/cfg_data
// only while no item is in flight; the block does not enforce this. cfg_ready
// is always high and unknown indexes are ignored. Reset loads the identity
// rotation and a zoom of 1.0 and clears every valid bit in the pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module camera_ray_direction_unit import camray_pkg::*; #(
  parameter int IMAGE_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam logic [23:0] RECIP   = 24'((64'd1 << 27) / IMAGE_WIDTH);
  localparam logic [12:0] WIDTH_C = 13'(IMAGE_WIDTH);
  localparam int          LATENCY = 11 + SQ_STEPS + DIV_STEPS + 1;

  function automatic logic signed [27:0] rsum(input logic signed [43:0] p,
                                               input logic signed [43:0] q,
                                               input logic sub);
    logic signed [44:0] s;
    s = sub ? (45'(p) - 45'(q)) : (45'(p) + 45'(q));
    return 28'(s >>> 15);
  endfunction

  function automatic logic [27:0] mag28(input logic signed [27:0] v);
    return v[27] ? 28'(-v) : 28'(v);
  endfunction

  function automatic logic signed [15:0] sat16(input logic [15:0] q, input logic neg);
    return neg ? 16'(-q) : (q[15] ? 16'sh7fff : q);
  endfunction

  logic signed [15:0] cos_x_r, sin_x_r, cos_y_r, sin_y_r, cos_z_r, sin_z_r, zoom_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_x_r <= 16'sh7fff;
      sin_x_r <= '0;
      cos_y_r <= 16'sh7fff;
      sin_y_r <= '0;
      cos_z_r <= 16'sh7fff;
      sin_z_r <= '0;
      zoom_r  <= 16'sh0100;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COS_X: cos_x_r <= cfg_data;
        REG_SIN_X: sin_x_r <= cfg_data;
        REG_COS_Y: cos_y_r <= cfg_data;
        REG_SIN_Y: sin_y_r <= cfg_data;
        REG_COS_Z: cos_z_r <= cfg_data;
        REG_SIN_Z: sin_z_r <= cfg_data;
        REG_ZOOM:  zoom_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stages 1 to 3 scale the pixel offset by 32768 / IMAGE_WIDTH.
  logic        s1_v_r, s2_v_r, s3_v_r;
  logic        s1_sx_r, s1_sy_r, s2_sx_r, s2_sy_r;
  logic [11:0] s1_mx_r, s1_my_r, s2_mx_r, s2_my_r;
  logic [23:0] s1_qx_r, s1_qy_r, s2_qx_r, s2_qy_r;
  logic [36:0] s2_px_r, s2_py_r;
  logic signed [27:0] s3_a_r, s3_b_r, s3_c_r;

  logic [11:0] mx_nxt, my_nxt;
  logic [35:0] rx_prod, ry_prod;
  logic [36:0] remx, remy;
  logic [23:0] qcx, qcy;

  always_comb begin
    mx_nxt  = in_data.pixel_x[11] ? 12'(-in_data.pixel_x) : 12'(in_data.pixel_x);
    my_nxt  = in_data.pixel_y[11] ? 12'(-in_data.pixel_y) : 12'(in_data.pixel_y);
    rx_prod = 36'(mx_nxt) * 36'(RECIP);
    ry_prod = 36'(my_nxt) * 36'(RECIP);
    remx    = {10'd0, s2_mx_r, 15'd0} - s2_px_r;
    remy    = {10'd0, s2_my_r, 15'd0} - s2_py_r;
    qcx     = s2_qx_r + 24'(remx >= 37'(WIDTH_C));
    qcy     = s2_qy_r + 24'(remy >= 37'(WIDTH_C));
  end

  always_ff @(posedge clk) begin
    s1_sx_r <= in_data.pixel_x[11];
    s1_sy_r <= in_data.pixel_y[11];
    s1_mx_r <= mx_nxt;
    s1_my_r <= my_nxt;
    s1_qx_r <= rx_prod[35:12];
    s1_qy_r <= ry_prod[35:12];
    s2_sx_r <= s1_sx_r;
    s2_sy_r <= s1_sy_r;
    s2_mx_r <= s1_mx_r;
    s2_my_r <= s1_my_r;
    s2_qx_r <= s1_qx_r;
    s2_qy_r <= s1_qy_r;
    s2_px_r <= 37'(s1_qx_r) * 37'(WIDTH_C);
    s2_py_r <= 37'(s1_qy_r) * 37'(WIDTH_C);
    s3_a_r  <= s2_sx_r ? -28'(qcx) : 28'(qcx);
    s3_b_r  <= s2_sy_r ? -28'(qcy) : 28'(qcy);
    s3_c_r  <= 28'($signed({zoom_r, 8'h00}));
  end

  // Stages 4 to 9 apply the rotations about X, Y and Z.
  logic s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r, s9_v_r, s10_v_r;
  logic signed [43:0] s4_p0_r, s4_p1_r, s4_p2_r, s4_p3_r;
  logic signed [43:0] s6_p0_r, s6_p1_r, s6_p2_r, s6_p3_r;
  logic signed [43:0] s8_p0_r, s8_p1_r, s8_p2_r, s8_p3_r;
  logic signed [27:0] s4_a_r, s5_a_r, s5_y_r, s5_z_r, s6_y_r, s7_y_r, s7_x1_r, s7_z1_r;
  logic signed [27:0] s8_z1_r, s9_x_r, s9_y_r, s9_z_r, s10_x_r, s10_y_r, s10_z_r;
  logic signed [55:0] s10_xx_r, s10_yy_r, s10_zz_r;

  always_ff @(posedge clk) begin
    s4_p0_r  <= 44'(s3_b_r) * 44'(cos_x_r);
    s4_p1_r  <= 44'(s3_c_r) * 44'(sin_x_r);
    s4_p2_r  <= 44'(s3_c_r) * 44'(cos_x_r);
    s4_p3_r  <= 44'(s3_b_r) * 44'(sin_x_r);
    s4_a_r   <= s3_a_r;
    s5_y_r   <= rsum(s4_p0_r, s4_p1_r, 1'b0);
    s5_z_r   <= rsum(s4_p2_r, s4_p3_r, 1'b1);
    s5_a_r   <= s4_a_r;
    s6_p0_r  <= 44'(s5_a_r) * 44'(cos_y_r);
    s6_p1_r  <= 44'(s5_z_r) * 44'(sin_y_r);
    s6_p2_r  <= 44'(s5_z_r) * 44'(cos_y_r);
    s6_p3_r  <= 44'(s5_a_r) * 44'(sin_y_r);
    s6_y_r   <= s5_y_r;
    s7_x1_r  <= rsum(s6_p0_r, s6_p1_r, 1'b0);
    s7_z1_r  <= rsum(s6_p2_r, s6_p3_r, 1'b1);
    s7_y_r   <= s6_y_r;
    s8_p0_r  <= 44'(s7_x1_r) * 44'(cos_z_r);
    s8_p1_r  <= 44'(s7_y_r) * 44'(sin_z_r);
    s8_p2_r  <= 44'(s7_x1_r) * 44'(sin_z_r);
    s8_p3_r  <= 44'(s7_y_r) * 44'(cos_z_r);
    s8_z1_r  <= s7_z1_r;
    s9_x_r   <= rsum(s8_p0_r, s8_p1_r, 1'b1);
    s9_y_r   <= rsum(s8_p2_r, s8_p3_r, 1'b0);
    s9_z_r   <= s8_z1_r;
    s10_xx_r <= 56'(s9_x_r) * 56'(s9_x_r);
    s10_yy_r <= 56'(s9_y_r) * 56'(s9_y_r);
    s10_zz_r <= 56'(s9_z_r) * 56'(s9_z_r);
    s10_x_r  <= s9_x_r;
    s10_y_r  <= s9_y_r;
    s10_z_r  <= s9_z_r;
  end

  // Square root pipeline; element 0 holds the squared length.
  logic [53:0]        sq_n_r    [0:SQ_STEPS];
  logic [53:0]        sq_res_r  [0:SQ_STEPS];
  logic signed [27:0] sq_x_r    [0:SQ_STEPS];
  logic signed [27:0] sq_y_r    [0:SQ_STEPS];
  logic signed [27:0] sq_z_r    [0:SQ_STEPS];
  logic               sq_zero_r [0:SQ_STEPS];
  logic               sq_v_r    [0:SQ_STEPS];
  logic [53:0]        len2_nxt;

  assign len2_nxt = s10_xx_r[53:0] + s10_yy_r[53:0] + s10_zz_r[53:0];

  always_ff @(posedge clk) begin
    sq_n_r[0]    <= len2_nxt;
    sq_res_r[0]  <= '0;
    sq_x_r[0]    <= s10_x_r;
    sq_y_r[0]    <= s10_y_r;
    sq_z_r[0]    <= s10_z_r;
    sq_zero_r[0] <= (len2_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
      s5_v_r    <= 1'b0;
      s6_v_r    <= 1'b0;
      s7_v_r    <= 1'b0;
      s8_v_r    <= 1'b0;
      s9_v_r    <= 1'b0;
      s10_v_r   <= 1'b0;
      sq_v_r[0] <= 1'b0;
    end else begin
      s1_v_r    <= start && !busy;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      s5_v_r    <= s4_v_r;
      s6_v_r    <= s5_v_r;
      s7_v_r    <= s6_v_r;
      s8_v_r    <= s7_v_r;
      s9_v_r    <= s8_v_r;
      s10_v_r   <= s9_v_r;
      sq_v_r[0] <= s10_v_r;
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    localparam logic [53:0] BITC = 54'd1 << (52 - 2 * i);
    logic [53:0] trial;
    logic        take;

    always_comb begin
      trial = sq_res_r[i] + BITC;
      take  = sq_n_r[i] >= trial;
    end

    always_ff @(posedge clk) begin
      sq_n_r[i+1]    <= take ? sq_n_r[i] - trial : sq_n_r[i];
      sq_res_r[i+1]  <= take ? (sq_res_r[i] >> 1) + BITC : sq_res_r[i] >> 1;
      sq_x_r[i+1]    <= sq_x_r[i];
      sq_y_r[i+1]    <= sq_y_r[i];
      sq_z_r[i+1]    <= sq_z_r[i];
      sq_zero_r[i+1] <= sq_zero_r[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[i+1] <= 1'b0;
      end else begin
        sq_v_r[i+1] <= sq_v_r[i];
      end
    end
  end

  // Division pipeline: one quotient bit of |V| * 32768 / L per stage, three lanes.
  logic [2:0][28:0] dv_rem_r  [1:DIV_STEPS];
  logic [2:0][15:0] dv_q_r    [1:DIV_STEPS];
  logic [2:0]       dv_neg_r  [1:DIV_STEPS];
  logic [27:0]      dv_len_r  [1:DIV_STEPS];
  logic             dv_zero_r [1:DIV_STEPS];
  logic             dv_v_r    [1:DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [2:0][28:0] rin, rout;
    logic [2:0][15:0] qin, qout;
    logic [2:0]       negin;
    logic [27:0]      lin;
    logic             zin, vin;

    if (k == 0) begin : g_first
      always_comb begin
        vin    = sq_v_r[SQ_STEPS];
        zin    = sq_zero_r[SQ_STEPS];
        lin    = sq_res_r[SQ_STEPS][27:0];
        negin  = {sq_z_r[SQ_STEPS][27], sq_y_r[SQ_STEPS][27], sq_x_r[SQ_STEPS][27]};
        rin[0] = {1'b0, mag28(sq_x_r[SQ_STEPS])};
        rin[1] = {1'b0, mag28(sq_y_r[SQ_STEPS])};
        rin[2] = {1'b0, mag28(sq_z_r[SQ_STEPS])};
        qin    = '0;
      end
    end else begin : g_next
      always_comb begin
        vin   = dv_v_r[k];
        zin   = dv_zero_r[k];
        lin   = dv_len_r[k];
        negin = dv_neg_r[k];
        qin   = dv_q_r[k];
        for (int l = 0; l < 3; l++) begin
          rin[l] = {dv_rem_r[k][l][27:0], 1'b0};
        end
      end
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (rin[l] >= {1'b0, lin}) begin
          rout[l] = rin[l] - {1'b0, lin};
          qout[l] = {qin[l][14:0], 1'b1};
        end else begin
          rout[l] = rin[l];
          qout[l] = {qin[l][14:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      dv_rem_r[k+1]  <= rout;
      dv_q_r[k+1]    <= qout;
      dv_neg_r[k+1]  <= negin;
      dv_len_r[k+1]  <= lin;
      dv_zero_r[k+1] <= zin;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else begin
        dv_v_r[k+1] <= vin;
      end
    end
  end

  logic      out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (dv_zero_r[DIV_STEPS]) begin
      out_data_r <= '{dir_x: '0, dir_y: '0, dir_z: '0, zero_length: 1'b1};
    end else begin
      out_data_r.dir_x       <= sat16(dv_q_r[DIV_STEPS][0], dv_neg_r[DIV_STEPS][0]);
      out_data_r.dir_y       <= sat16(dv_q_r[DIV_STEPS][1], dv_neg_r[DIV_STEPS][1]);
      out_data_r.dir_z       <= sat16(dv_q_r[DIV_STEPS][2], dv_neg_r[DIV_STEPS][2]);
      out_data_r.zero_length <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_SAME(a_latency, start && !busy, ##LATENCY out_valid, "result missing after latency")
  `ASSERT_SAME(a_zero_out, out_valid && out_data.zero_length,
    out_data.dir_x == 0 && out_data.dir_y == 0 && out_data.dir_z == 0, "zero flag with data")
  `ASSERT_SAME(a_unit_out, out_valid && !out_data.zero_length,
    out_data.dir_x != 0 || out_data.dir_y != 0 || out_data.dir_z != 0, "unit ray is all zero")
  `ASSERT_NEXT(a_len_order, s10_v_r, sq_v_r[0], "length stage out of step")

endmodule

// File: test/camera_ray_direction_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera ray direction unit testbench
// Loads several camera orientations and zoom values, streams pixel offsets
// through the unit with random gaps in all but one phase, and compares every
// ray direction with a bit-exact model of the rotation and normalization.
// ----------------------------------------------------------------------------
module camera_ray_direction_unit_test;
  import camray_pkg::*;

  localparam int IMAGE_WIDTH = 1024;
  localparam int LATENCY = 55;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct {
    logic signed [11:0] px;
    logic signed [11:0] py;
    bit                 known;
    out_item_t          want;
  } pixel_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_data;
  logic out_valid;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  logic signed [15:0] camera_regs [7];
  out_item_t pending_rays [$];
  int error_count = 0;
  int ray_count = 0;
  int zero_count = 0;
  int cycle_count = 0;
  bit steady_phase = 0;
  pixel_row_t pixel_table [$];

  camera_ray_direction_unit #(.IMAGE_WIDTH(IMAGE_WIDTH)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("camera_ray_direction_unit_test: errors");
      $finish;
    end
  end

  function automatic longint floor_shift15(longint v);
    return v >>> 15;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] unit_q15(longint v, longint len);
    longint q;
    q = (v * 32768) / len;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic out_item_t predict_ray(logic signed [11:0] px, logic signed [11:0] py);
    longint a, b, c, y, z, x1, z1, vx, vy, vz, len;
    longint cx, sx, cy, sy, cz, sz;
    longint unsigned len2;
    out_item_t r;
    cx = camera_regs[REG_COS_X]; sx = camera_regs[REG_SIN_X];
    cy = camera_regs[REG_COS_Y]; sy = camera_regs[REG_SIN_Y];
    cz = camera_regs[REG_COS_Z]; sz = camera_regs[REG_SIN_Z];
    a = (longint'(px) * 65536) / (2 * IMAGE_WIDTH);
    b = (longint'(py) * 65536) / (2 * IMAGE_WIDTH);
    c = longint'(camera_regs[REG_ZOOM]) * 256;
    y = floor_shift15(b * cx + c * sx);
    z = floor_shift15(c * cx - b * sx);
    x1 = floor_shift15(a * cy + z * sy);
    z1 = floor_shift15(z * cy - a * sy);
    vx = floor_shift15(x1 * cz - y * sz);
    vy = floor_shift15(x1 * sz + y * cz);
    vz = z1;
    len2 = vx * vx + vy * vy + vz * vz;
    if (len2 == 0) begin
      r = '0;
      r.zero_length = 1'b1;
      return r;
    end
    len = root_floor(len2);
    if (len < 1) len = 1;
    r.dir_x = unit_q15(vx, len);
    r.dir_y = unit_q15(vy, len);
    r.dir_z = unit_q15(vz, len);
    r.zero_length = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      ray_count++;
      if (pending_rays.size() == 0) begin
        $error("ray direction arrived with nothing pending");
        error_count++;
      end else begin
        want = pending_rays.pop_front();
        if (out_data.zero_length) zero_count++;
        if (out_data.dir_x !== want.dir_x) begin
          $error("dir_x expected %0d actual %0d", want.dir_x, out_data.dir_x);
          error_count++;
        end
        if (out_data.dir_y !== want.dir_y) begin
          $error("dir_y expected %0d actual %0d", want.dir_y, out_data.dir_y);
          error_count++;
        end
        if (out_data.dir_z !== want.dir_z) begin
          $error("dir_z expected %0d actual %0d", want.dir_z, out_data.dir_z);
          error_count++;
        end
        if (out_data.zero_length !== want.zero_length) begin
          $error("zero_length expected %0b actual %0b", want.zero_length,
                 out_data.zero_length);
          error_count++;
        end
      end
    end
  end

  task automatic write_camera_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx <= REG_ZOOM) camera_regs[idx] = value;
    @(posedge clk);
  endtask

  task automatic drain_rays();
    while (pending_rays.size() != 0) @(posedge clk);
    repeat (LATENCY / 4) @(posedge clk);
  endtask

  task automatic send_pixel(logic signed [11:0] px, logic signed [11:0] py, bit known,
                            out_item_t want);
    out_item_t pred;
    if (!steady_phase) begin
      while ($urandom_range(99) < 16) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    pred = predict_ray(px, py);
    if (known && pred !== want) begin
      $error("table row (%0d,%0d) disagrees with prediction", px, py);
      error_count++;
    end
    start <= 1'b1;
    in_data <= '{pixel_x: px, pixel_y: py};
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rays.push_back(pred);
  endtask

  task automatic load_orientation(logic [15:0] cx, logic [15:0] sx, logic [15:0] cy,
                                  logic [15:0] sy, logic [15:0] cz, logic [15:0] sz,
                                  logic [15:0] zoom);
    write_camera_reg(REG_COS_X, cx);
    write_camera_reg(REG_SIN_X, sx);
    write_camera_reg(REG_COS_Y, cy);
    write_camera_reg(REG_SIN_Y, sy);
    write_camera_reg(REG_COS_Z, cz);
    write_camera_reg(REG_SIN_Z, sz);
    write_camera_reg(REG_ZOOM, zoom);
  endtask

  task automatic random_pixels(int count);
    logic signed [11:0] px, py;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: begin
          px = 12'($urandom_range(4095));
          py = 12'($urandom_range(4095));
        end
        1: begin
          px = $urandom_range(1) ? 12'sh800 : 12'sh7FF;
          py = 12'($urandom_range(63) - 32);
        end
        2: begin
          px = 12'($urandom_range(15) - 8);
          py = $urandom_range(1) ? 12'sh7FF : 12'sh800;
        end
        default: begin
          px = 12'($urandom_range(31) - 16);
          py = 12'($urandom_range(31) - 16);
        end
      endcase
      send_pixel(px, py, 1'b0, '0);
    end
    start <= 1'b0;
  endtask

  initial begin
    out_item_t want;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    camera_regs[REG_COS_X] = 16'sd32767; camera_regs[REG_SIN_X] = 16'sd0;
    camera_regs[REG_COS_Y] = 16'sd32767; camera_regs[REG_SIN_Y] = 16'sd0;
    camera_regs[REG_COS_Z] = 16'sd32767; camera_regs[REG_SIN_Z] = 16'sd0;
    camera_regs[REG_ZOOM] = 16'sd256;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset the camera looks straight down z with unit zoom.
    want = '{dir_x: 16'sd0, dir_y: 16'sd0, dir_z: 16'sd32767, zero_length: 1'b0};
    pixel_table.push_back('{12'sd0, 12'sd0, 1'b1, want});
    pixel_table.push_back('{12'sh7FF, 12'sh7FF, 1'b0, '0});
    pixel_table.push_back('{12'sh800, 12'sh800, 1'b0, '0});
    pixel_table.push_back('{12'sh800, 12'sh7FF, 1'b0, '0});
    pixel_table.push_back('{12'sh7FF, 12'sh800, 1'b0, '0});
    pixel_table.push_back('{12'sd1, 12'sd0, 1'b0, '0});
    pixel_table.push_back('{-12'sd1, 12'sd0, 1'b0, '0});
    pixel_table.push_back('{12'sd0, 12'sd1, 1'b0, '0});
    pixel_table.push_back('{12'sh555, 12'shAAA, 1'b0, '0});
    pixel_table.push_back('{12'shAAA, 12'sh555, 1'b0, '0});
    foreach (pixel_table[i])
      send_pixel(pixel_table[i].px, pixel_table[i].py, pixel_table[i].known,
                 pixel_table[i].want);
    start <= 1'b0;
    drain_rays();

    // Zero zoom on the optical axis gives a zero-length vector.
    write_camera_reg(REG_ZOOM, 16'sd0);
    write_camera_reg(CFG_UNUSED_IDX, 16'h1234);
    want = '{dir_x: 16'sd0, dir_y: 16'sd0, dir_z: 16'sd0, zero_length: 1'b1};
    send_pixel(12'sd0, 12'sd0, 1'b1, want);
    send_pixel(12'sd1, 12'sd0, 1'b0, '0);
    send_pixel(12'sh7FF, 12'sh800, 1'b0, '0);
    start <= 1'b0;
    drain_rays();

    // Extreme register patterns, including non-unit angles.
    load_orientation(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                     16'h7FFF);
    send_pixel(12'sh7FF, 12'sh800, 1'b0, '0);
    send_pixel(12'sh800, 12'sh7FF, 1'b0, '0);
    send_pixel(12'sd0, 12'sd0, 1'b0, '0);
    random_pixels(150);
    drain_rays();
    load_orientation(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                     16'h8000);
    random_pixels(150);
    drain_rays();
    load_orientation(16'h0000, 16'hFFFF, 16'h5A82, 16'h5A82, 16'hA57E, 16'h5A82,
                     16'h0001);
    random_pixels(150);
    drain_rays();

    steady_phase = 1;
    for (int k = 0; k < 4; k++) begin
      load_orientation(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom),
                       $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(2048)));
      random_pixels(200);
      drain_rays();
      steady_phase = 0;
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (pending_rays.size() != 0) begin
      $error("%0d ray directions never arrived", pending_rays.size());
      error_count++;
    end
    $display("Checked %0d ray directions (%0d zero-length) over nine camera setups.",
             ray_count, zero_count);
    if (error_count == 0) begin
      $display("camera_ray_direction_unit_test: clean");
    end else begin
      $display("camera_ray_direction_unit_test: errors");
    end
    $finish;
  end
endmodule

// File: camera_ray_direction_unit.f
+incdir+rtl/core
rtl/core/camray_pkg.sv
rtl/core/camera_ray_direction_unit.sv
test/camera_ray_direction_unit_test.sv
